### src/rphc_pkg.sv
`default_nettype none

package rphc_pkg;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_CSUM    = 3'd2,
		ST_VERSION = 3'd3,
		ST_LENGTH  = 3'd4
	} status_t;

	localparam logic [16:0] MIN_LEN     = 17'd24;
	localparam logic [7:0]  OSPF_VER    = 8'd2;
	localparam logic [16:0] CSUM_POS    = 17'd12;
	localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

	typedef struct packed {
		status_t     status;
		logic [7:0]  packet_type;
		logic [15:0] packet_length;
		logic [31:0] origin_router;
		logic [31:0] area_id;
	} result_t;

	// One's-complement add with end-around carry.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, w};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

`default_nettype wire

### src/routing_packet_header_checker.sv
// OSPFv2 packet header checker.
// Input channel (data_valid/data_ready): one packet byte per request in
// data_byte, with last_byte high on the final byte of the packet.
// Output channel (result_valid/result_ready): one result per packet, issued
// for the final byte: status (ok, too short, checksum, version, length),
// packet_length (byte count, saturated) and, on ok, packet_type, origin_router
// and area_id (zero otherwise).
// A byte is captured in an input register and folded into the running count,
// checksum and header fields as it leaves that register; a final byte also
// loads its result into the output register as it leaves, which a stall delays.
// Throughput is one byte per cycle while no final byte is held by a stall,
// set by the single input register feeding the one-word checksum adder.
// While the receiver stalls, bytes keep flowing until a final byte reaches
// the input register with an untaken result still held; input ready drops
// only then.
// Reset clears the packet state, both registers' valid flags and the
// checksum; the block is ready for the first byte of a packet after reset.
`default_nettype none

module routing_packet_header_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       status,
	output logic [7:0]       packet_type,
	output logic [15:0]      packet_length,
	output logic [31:0]      origin_router,
	output logic [31:0]      area_id
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              stall, advance;
	rphc_pkg::result_t res;
	rphc_pkg::result_t res_q;
	logic              result_valid_q;

	// only a final byte needs room in the output register
	assign stall      = valid_s1 && last_s1 && result_valid_q && !result_ready;
	assign advance    = valid_s1 && !stall;
	assign data_ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && data_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	rphc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.last   (last_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign result_valid  = result_valid_q;
	assign status        = res_q.status;
	assign packet_type   = res_q.packet_type;
	assign packet_length = res_q.packet_length;
	assign origin_router = res_q.origin_router;
	assign area_id       = res_q.area_id;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !stall |=> result_valid_q)
		else $error("final byte did not produce a result");

	a_ok_min_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && res_q.status == rphc_pkg::ST_OK |-> res_q.packet_length >= 16'd24)
		else $error("ok result with a packet shorter than the header");

	a_fail_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && res_q.status != rphc_pkg::ST_OK
		|-> res_q.origin_router == 32'd0 && res_q.area_id == 32'd0
			&& res_q.packet_type == 8'd0)
		else $error("failed result carries header fields");

endmodule

`default_nettype wire

### src/rphc_core.sv
`default_nettype none

module rphc_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       data,
	input  wire logic             last,
	output rphc_pkg::result_t     res
);

	logic [16:0] count_q, count_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  pend_q, pend_n;
	logic [7:0]  ver_q, ver_n;
	logic [7:0]  type_q, type_n;
	logic [15:0] dlen_q, dlen_n;
	logic [15:0] csum_q, csum_n;
	logic [31:0] router_q, router_n;
	logic [31:0] area_q, area_n;

	logic        live, in_csum, odd;
	logic [7:0]  sb;
	logic [15:0] word;
	rphc_pkg::status_t st;

	always_comb begin
		live    = count_q != rphc_pkg::COUNT_MAX;
		in_csum = (count_q == rphc_pkg::CSUM_POS) || (count_q == rphc_pkg::CSUM_POS + 17'd1);
		odd     = count_q[0];
		sb      = in_csum ? 8'h00 : data;
		// an odd final byte is padded with a zero low byte
		word    = odd ? {pend_q, sb} : {sb, 8'h00};

		count_n  = count_q;
		sum_n    = sum_q;
		pend_n   = pend_q;
		ver_n    = ver_q;
		type_n   = type_q;
		dlen_n   = dlen_q;
		csum_n   = csum_q;
		router_n = router_q;
		area_n   = area_q;

		if (live) begin
			count_n = count_q + 17'd1;
			if (odd || last)
				sum_n = rphc_pkg::ones_add(sum_q, word);
			if (!odd)
				pend_n = sb;
			if (count_q == 17'd0)
				ver_n = data;
			else if (count_q == 17'd1)
				type_n = data;
			else if (count_q < 17'd4)
				dlen_n = {dlen_q[7:0], data};
			else if (count_q < 17'd8)
				router_n = {router_q[23:0], data};
			else if (count_q < 17'd12)
				area_n = {area_q[23:0], data};
			else if (in_csum)
				csum_n = {csum_q[7:0], data};
		end

		if (count_n < rphc_pkg::MIN_LEN)
			st = rphc_pkg::ST_SHORT;
		else if (csum_n != ~sum_n)
			st = rphc_pkg::ST_CSUM;
		else if (ver_n != rphc_pkg::OSPF_VER)
			st = rphc_pkg::ST_VERSION;
		else if ({1'b0, dlen_n} != count_n)
			st = rphc_pkg::ST_LENGTH;
		else
			st = rphc_pkg::ST_OK;

		res.status        = st;
		res.packet_type   = (st == rphc_pkg::ST_OK) ? type_n : 8'h00;
		res.packet_length = count_n[16] ? 16'hFFFF : count_n[15:0];
		res.origin_router = (st == rphc_pkg::ST_OK) ? router_n : 32'd0;
		res.area_id       = (st == rphc_pkg::ST_OK) ? area_n : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			pend_q   <= '0;
			ver_q    <= '0;
			type_q   <= '0;
			dlen_q   <= '0;
			csum_q   <= '0;
			router_q <= '0;
			area_q   <= '0;
		end else if (step) begin
			if (last) begin
				// clear for the next packet
				count_q  <= '0;
				sum_q    <= '0;
				pend_q   <= '0;
				ver_q    <= '0;
				type_q   <= '0;
				dlen_q   <= '0;
				csum_q   <= '0;
				router_q <= '0;
				area_q   <= '0;
			end else begin
				count_q  <= count_n;
				sum_q    <= sum_n;
				pend_q   <= pend_n;
				ver_q    <= ver_n;
				type_q   <= type_n;
				dlen_q   <= dlen_n;
				csum_q   <= csum_n;
				router_q <= router_n;
				area_q   <= area_n;
			end
		end
	end

endmodule

`default_nettype wire
